/* sv/sci_pkg.sv */
// ----------------------------------------------------------------------------
// sci_pkg
// Shared types and constants for the sample confidence interval block.
// ----------------------------------------------------------------------------
`default_nettype none

package sci_pkg;

  localparam int MaxSamplesDefault = 4096;
  localparam logic [15:0] QuantileReset = 16'd8028;

  typedef enum logic [1:0] {
    ST_ACC,
    ST_CHECK,
    ST_RUN,
    ST_FIN
  } state_t;

  // Arithmetic steps, issued in this order
  typedef enum logic [3:0] {
    OP_MEAN_DIV,
    OP_NSQ_MUL,
    OP_SSQ_MUL,
    OP_NN_MUL,
    OP_VAR_DIV,
    OP_S_SQRT,
    OP_P_MUL,
    OP_PP_MUL,
    OP_H_DIV,
    OP_H_SQRT
  } op_t;

  typedef enum logic [1:0] {
    RES_OK  = 2'd0,
    RES_FEW = 2'd1,
    RES_OVF = 2'd2
  } res_t;

  typedef struct packed {
    logic in_ready;
    logic start;
    op_t  op;
    logic load_out;
    res_t code;
  } ctrl_cmd_t;

  typedef struct packed {
    logic busy;
    logic ovf;
    logic few;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

/* sv/sci_ctrl.sv */
// ----------------------------------------------------------------------------
// sci_ctrl
// Sequencer: accumulation, special-case check, arithmetic steps, result load.
// ----------------------------------------------------------------------------
`default_nettype none

module sci_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  input  wire                  in_last,
  input  sci_pkg::dp_status_t  stat,
  output sci_pkg::ctrl_cmd_t   cmd
);
  import sci_pkg::*;

  state_t state, state_next;
  op_t    step, step_next;
  logic   issued, issued_next;
  res_t   code, code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_ACC;
      step   <= OP_MEAN_DIV;
      issued <= 1'b0;
      code   <= RES_OK;
    end else begin
      state  <= state_next;
      step   <= step_next;
      issued <= issued_next;
      code   <= code_next;
    end
  end

  always_comb begin
    state_next   = state;
    step_next    = step;
    issued_next  = issued;
    code_next    = code;
    cmd.in_ready = 1'b0;
    cmd.start    = 1'b0;
    cmd.op       = step;
    cmd.load_out = 1'b0;
    cmd.code     = code;
    unique case (state)
      ST_ACC: begin
        cmd.in_ready = 1'b1;
        if (in_valid && in_last) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        step_next   = OP_MEAN_DIV;
        issued_next = 1'b0;
        priority if (stat.ovf) begin
          code_next  = RES_OVF;
          state_next = ST_FIN;
        end else if (stat.few) begin
          code_next  = RES_FEW;
          state_next = ST_FIN;
        end else begin
          code_next  = RES_OK;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!issued) begin
          cmd.start   = 1'b1;
          issued_next = 1'b1;
        end else if (!stat.busy) begin
          issued_next = 1'b0;
          if (step == OP_H_SQRT) state_next = ST_FIN;
          else step_next = op_t'(step + 1'b1);
        end
      end
      ST_FIN: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_ACC;
        end
      end
      default: state_next = ST_ACC;
    endcase
  end

endmodule

`default_nettype wire

/* sv/sci_dp.sv */
// ----------------------------------------------------------------------------
// sci_dp
// Datapath: running sums, shift-add multiplier, restoring divider,
// bit-pair square root, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sci_dp #(
  parameter int MAX_SAMPLES = sci_pkg::MaxSamplesDefault
) (
  input  wire                  clk,
  input  wire                  rst,
  input  sci_pkg::ctrl_cmd_t   cmd,
  output sci_pkg::dp_status_t  stat,
  input  wire                  in_valid,
  input  wire  [23:0]          in_sample,
  input  wire                  cfg_we,
  input  wire  [15:0]          cfg_wdata,
  input  wire                  out_ready,
  output logic                 out_valid,
  output logic [135:0]         out_data
);
  import sci_pkg::*;

  logic        [12:0] cnt;
  logic signed [35:0] sum;
  logic        [58:0] sqs;
  logic               ovf;
  logic        [15:0] quant;

  logic [23:0] ax;
  logic [47:0] ax_sq;
  logic [35:0] as;
  logic        acc_fire;

  op_t         op_q;
  logic        busy;
  logic [6:0]  e_cnt;

  logic [79:0] m_acc, m_a;
  logic [39:0] m_b;
  logic [71:0] d_q;
  logic [23:0] d_r, d_d;
  logic [24:0] d_trial;
  logic [63:0] s_x;
  logic [31:0] s_root;
  logic [33:0] s_rem;
  logic [35:0] s_rem2, s_trial;

  logic [23:0] mean_r;
  logic [70:0] num_r;
  logic [23:0] dd_r;
  logic [63:0] var_r;
  logic [24:0] s_r;
  logic [39:0] p_r;
  logic [55:0] sh_r;
  logic [55:0] v_r;
  logic [27:0] h_r;

  logic [23:0] o_mean;
  logic [31:0] o_lo, o_hi, o_width;
  logic [12:0] o_cnt;
  res_t        o_code;
  logic [31:0] mean_ext, h_ext;

  assign acc_fire = in_valid && cmd.in_ready;
  assign ax       = in_sample[23] ? 24'(-in_sample) : in_sample;
  assign ax_sq    = ax * ax;
  assign as       = sum[35] ? 36'(-sum) : 36'(sum);
  assign d_trial  = {d_r, d_q[71]};
  assign s_rem2   = {s_rem, s_x[63:62]};
  assign s_trial  = {2'b00, s_root, 2'b01};
  assign mean_ext = {{8{mean_r[23]}}, mean_r};
  assign h_ext    = {4'b0, h_r};

  assign stat.busy     = busy;
  assign stat.ovf      = ovf;
  assign stat.few      = cnt < 13'd2;
  assign stat.out_free = !out_valid || out_ready;

  assign out_data = {1'b0, o_code, o_cnt, o_width, o_hi, o_lo, o_mean};

  always_ff @(posedge clk) begin
    if (rst) quant <= QuantileReset;
    else if (cfg_we) quant <= cfg_wdata;
  end

  // Running sums
  always_ff @(posedge clk) begin
    if (rst || cmd.load_out) begin
      cnt <= '0;
      sum <= '0;
      sqs <= '0;
      ovf <= 1'b0;
    end else if (acc_fire) begin
      if (cnt < 13'(MAX_SAMPLES)) begin
        cnt <= cnt + 13'd1;
        sum <= sum + 36'(signed'(in_sample));
        sqs <= sqs + {11'b0, ax_sq};
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  // Shared arithmetic units
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (cmd.start) begin
      busy <= 1'b1;
      op_q <= cmd.op;
      m_acc  <= '0;
      d_r    <= '0;
      s_root <= '0;
      s_rem  <= '0;
      unique case (cmd.op)
        OP_MEAN_DIV: begin
          d_q <= {36'b0, as}; d_d <= {11'b0, cnt}; e_cnt <= 7'd72;
        end
        OP_VAR_DIV: begin
          d_q <= {1'b0, num_r}; d_d <= dd_r; e_cnt <= 7'd72;
        end
        OP_H_DIV: begin
          d_q <= {16'b0, sh_r}; d_d <= {11'b0, cnt}; e_cnt <= 7'd72;
        end
        OP_S_SQRT: begin
          s_x <= var_r; e_cnt <= 7'd32;
        end
        OP_H_SQRT: begin
          s_x <= {8'b0, v_r}; e_cnt <= 7'd32;
        end
        OP_NSQ_MUL: begin
          m_a <= {21'b0, sqs}; m_b <= {27'b0, cnt};
        end
        OP_SSQ_MUL: begin
          m_a <= {44'b0, as}; m_b <= as[35:0] == '0 ? '0 : {4'b0, as};
        end
        OP_NN_MUL: begin
          m_a <= {67'b0, cnt}; m_b <= {27'b0, cnt - 13'd1};
        end
        OP_P_MUL: begin
          m_a <= {55'b0, s_r}; m_b <= {24'b0, quant};
        end
        OP_PP_MUL: begin
          m_a <= {40'b0, p_r}; m_b <= p_r;
        end
        default: begin
          m_a <= '0; m_b <= '0;
        end
      endcase
    end else if (busy) begin
      unique case (op_q)
        OP_MEAN_DIV, OP_VAR_DIV, OP_H_DIV: begin
          if (e_cnt != 7'd0) begin
            e_cnt <= e_cnt - 7'd1;
            if (d_trial >= {1'b0, d_d}) begin
              d_r <= 24'(d_trial - {1'b0, d_d});
              d_q <= {d_q[70:0], 1'b1};
            end else begin
              d_r <= d_trial[23:0];
              d_q <= {d_q[70:0], 1'b0};
            end
          end else begin
            busy <= 1'b0;
            unique case (op_q)
              OP_MEAN_DIV: mean_r <= sum[35] ? ~d_q[23:0] + {23'b0, d_r == '0}
                                             : d_q[23:0];
              OP_VAR_DIV:  var_r <= d_q[63:0];
              default:     v_r <= d_q[55:0];
            endcase
          end
        end
        OP_S_SQRT, OP_H_SQRT: begin
          if (e_cnt != 7'd0) begin
            e_cnt <= e_cnt - 7'd1;
            s_x   <= {s_x[61:0], 2'b00};
            if (s_rem2 >= s_trial) begin
              s_rem  <= 34'(s_rem2 - s_trial);
              s_root <= {s_root[30:0], 1'b1};
            end else begin
              s_rem  <= s_rem2[33:0];
              s_root <= {s_root[30:0], 1'b0};
            end
          end else begin
            busy <= 1'b0;
            if (op_q == OP_S_SQRT) s_r <= s_root[24:0];
            else h_r <= s_root[27:0];
          end
        end
        default: begin
          if (m_b != '0) begin
            if (m_b[0]) m_acc <= m_acc + m_a;
            m_a <= {m_a[78:0], 1'b0};
            m_b <= {1'b0, m_b[39:1]};
          end else begin
            busy <= 1'b0;
            unique case (op_q)
              OP_NSQ_MUL: num_r <= m_acc[70:0];
              OP_SSQ_MUL: num_r <= num_r - m_acc[70:0];
              OP_NN_MUL:  dd_r  <= m_acc[23:0];
              OP_P_MUL:   p_r   <= m_acc[39:0];
              default:    sh_r  <= m_acc[79:24];
            endcase
          end
        end
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.load_out) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      o_cnt  <= cnt;
      o_code <= cmd.code;
      if (cmd.code == RES_OK) begin
        o_mean  <= mean_r;
        o_lo    <= mean_ext - h_ext;
        o_hi    <= mean_ext + h_ext;
        o_width <= {3'b0, h_r, 1'b0};
      end else begin
        o_mean  <= '0;
        o_lo    <= '0;
        o_hi    <= '0;
        o_width <= '0;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/sample_confidence_interval.sv */
// ----------------------------------------------------------------------------
// sample_confidence_interval
// Mean, sample deviation and confidence bounds over a run of Q11.12 samples.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle; the transaction with tlast closes the set
// and stalls the input while the result is worked out: a floor divide of the
// sum, shift-add products, a division of the 71-bit numerator, a square root,
// the quantile product and its square, a third division and a second root, all
// done by the bit-serial multiplier (one bit a cycle, up to 40), the 72-step
// restoring divider (used three times) and the 32-step square root (twice).
// A set of one sample returns status 1, a set past MAX_SAMPLES returns status
// 2, both with zero bounds. The result is held in an output register, so the
// next set starts while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module sample_confidence_interval #(
  parameter int MAX_SAMPLES = sci_pkg::MaxSamplesDefault
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [23:0]  s_axis_tdata,  // sample[23:0]
  input  wire          s_axis_tlast,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // mean_value[23:0], lower_bound[55:24], upper_bound[87:56],
  // interval_width[119:88], sample_count[132:120], status[134:133]
  output logic [135:0] m_axis_tdata,
  input  wire          cfg_we,
  input  wire  [15:0]  cfg_wdata
);
  import sci_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t stat;

  sci_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .stat     (stat),
    .cmd      (cmd)
  );

  sci_dp #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_valid  (s_axis_tvalid),
    .in_sample (s_axis_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata)
  );

  assign s_axis_tready = cmd.in_ready;

`ifndef NO_ASSERTIONS
  a_stall_after_last: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input not stalled after closing transaction");

  a_special_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[134:133] != RES_OK) |-> m_axis_tdata[119:0] == '0)
    else $error("special result carries nonzero bounds");

  a_width_even: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !m_axis_tdata[88])
    else $error("interval width odd");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[132:120] <= 13'(MAX_SAMPLES))
    else $error("sample count beyond limit");
`endif

endmodule

`default_nettype wire

/* tb/sample_confidence_interval_tb.sv */
// ----------------------------------------------------------------------------
// sample_confidence_interval_tb
// Drives sets of Q11.12 samples through the block, closing each with tlast,
// predicts mean, bounds, width, count and status per set, and checks every
// result transaction against the oldest prediction. Both sides idle at random except in the long set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sample_confidence_interval_tb;
  import sci_pkg::*;

  localparam int MaxSamples = 4096;
  localparam int LongSet = 120;
  localparam longint CycleLimit = 3000000;

  typedef struct packed {
    logic [1:0]  status;
    logic [12:0] sample_count;
    logic [31:0] interval_width;
    logic [31:0] upper_bound;
    logic [31:0] lower_bound;
    logic [23:0] mean_value;
  } ci_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  wire          s_axis_tready;
  logic [23:0]  s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  wire          m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  wire  [135:0] m_axis_tdata;
  logic         cfg_we = 1'b0;
  logic [15:0]  cfg_wdata = '0;

  sample_confidence_interval u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [15:0]  quantile_q = QuantileReset;
  logic [12:0]  set_count = '0;
  logic signed [35:0] set_sum = '0;
  logic [58:0]  set_sumsq = '0;
  logic         set_ovf = 1'b0;

  ci_result_t   expected_q[$];
  int           errors = 0;
  int           results_seen = 0;
  int           samples_sent = 0;
  longint       cycles = 0;
  bit           idle_enable = 1'b1;

  function automatic logic [63:0] root_floor(logic [127:0] x);
    logic [127:0] r;
    logic [127:0] b;
    r = 0;
    b = 128'd1 << 126;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[63:0];
  endfunction

  // absorbs one sample; returns 1 with the set's result when last is set
  function automatic bit interval_predict(logic [23:0] smp, bit lst, output ci_result_t res);
    logic signed [35:0] x;
    logic signed [63:0] mean;
    logic signed [63:0] lo;
    logic signed [63:0] hi;
    logic [127:0] num;
    logic [127:0] var_q;
    logic [63:0]  s;
    logic [127:0] p;
    logic [63:0]  h;
    logic [63:0]  n;
    logic [63:0]  as;
    logic [63:0]  w;
    x = $signed(smp);
    res = '0;
    if (set_count < MaxSamples) begin
      set_count = set_count + 13'd1;
      set_sum = set_sum + x;
      set_sumsq = set_sumsq + 59'(x * x);
    end else begin
      set_ovf = 1'b1;
    end
    if (!lst) return 0;
    n = 64'(set_count);
    res.sample_count = set_count;
    if (set_ovf) begin
      res.status = RES_OVF;
    end else if (n < 2) begin
      res.status = RES_FEW;
    end else begin
      res.status = RES_OK;
      mean = set_sum / $signed(n);
      if ((set_sum % $signed(n)) != 0 && set_sum < 0) mean = mean - 1;
      as = set_sum < 0 ? 64'(-set_sum) : 64'(set_sum);
      num = 128'(n) * 128'(set_sumsq) - 128'(as) * 128'(as);
      var_q = num / (128'(n) * 128'(n - 1));
      s = root_floor(128'(var_q[63:0]));
      p = 128'(quantile_q) * 128'(s);
      h = root_floor(((p * p) >> 24) / 128'(n));
      lo = mean - $signed(h);
      hi = mean + $signed(h);
      if (lo < -64'sd2147483648) lo = -64'sd2147483648;
      if (hi > 64'sd2147483647) hi = 64'sd2147483647;
      w = 2 * h;
      if (w > 64'hFFFF_FFFF) w = 64'hFFFF_FFFF;
      res.mean_value = mean[23:0];
      res.lower_bound = lo[31:0];
      res.upper_bound = hi[31:0];
      res.interval_width = w[31:0];
    end
    set_count = '0;
    set_sum = '0;
    set_sumsq = '0;
    set_ovf = 1'b0;
    return 1;
  endfunction

  function automatic bit idle_now();
    return idle_enable && ($urandom_range(99) < 17);
  endfunction

  // tvalid stays high after a transaction until the next idle cycle or drain
  task automatic send_sample(logic [23:0] smp, bit lst);
    ci_result_t r;
    while (idle_now()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= smp;
    s_axis_tlast <= lst;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (interval_predict(smp, lst, r)) expected_q.insert(expected_q.size(), r);
    samples_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_quantile(logic [15:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    quantile_q = v;
  endtask

  // checker
  always @(posedge clk) begin
    ci_result_t got;
    ci_result_t exp_r;
    cycles <= cycles + 1;
    if (!rst) m_axis_tready <= !idle_now();
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[134:0];
      results_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got.mean_value !== exp_r.mean_value) begin
          $display("%0t: mean exp %h got %h", $realtime, exp_r.mean_value, got.mean_value);
          errors++;
        end
        if (got.lower_bound !== exp_r.lower_bound) begin
          $display("%0t: lower exp %h got %h", $realtime, exp_r.lower_bound, got.lower_bound);
          errors++;
        end
        if (got.upper_bound !== exp_r.upper_bound) begin
          $display("%0t: upper exp %h got %h", $realtime, exp_r.upper_bound, got.upper_bound);
          errors++;
        end
        if (got.interval_width !== exp_r.interval_width) begin
          $display("%0t: width exp %h got %h", $realtime, exp_r.interval_width,
                   got.interval_width);
          errors++;
        end
        if (got.sample_count !== exp_r.sample_count) begin
          $display("%0t: count exp %0d got %0d", $realtime, exp_r.sample_count,
                   got.sample_count);
          errors++;
        end
        if (got.status !== exp_r.status) begin
          $display("%0t: status exp %0d got %0d", $realtime, exp_r.status, got.status);
          errors++;
        end
      end
    end
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    send_sample(24'h7FFFFF, 1'b1);               // single sample
    send_sample(24'h7FFFFF, 1'b0);
    send_sample(24'h800000, 1'b1);
    send_sample(24'h800000, 1'b0);
    send_sample(24'h800000, 1'b0);
    send_sample(24'h7FFFFF, 1'b1);
    send_sample(24'hFFFFFF, 1'b0);               // negative mean, floored
    send_sample(24'hFFFFFE, 1'b1);
    send_sample(24'h001000, 1'b0);               // zero variance
    send_sample(24'h001000, 1'b1);
    send_sample(24'h000000, 1'b0);
    send_sample(24'h000000, 1'b1);
    send_sample(24'h555555, 1'b0);
    send_sample(24'hAAAAAA, 1'b0);
    send_sample(24'h123456, 1'b1);
  endtask

  task automatic test_random_sets(int nsets);
    int len;
    for (int k = 0; k < nsets; k++) begin
      len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 12);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(3))
          0: send_sample(24'($urandom()), i == len - 1);
          1: send_sample(24'($signed($urandom_range(8000)) - 4000), i == len - 1);
          2: send_sample($urandom_range(1) ? 24'(24'h7FFF00 | $urandom_range(255))
                                           : 24'(24'h800000 | $urandom_range(255)),
                         i == len - 1);
          default: send_sample(24'(24'h001000 + $urandom_range(63)), i == len - 1);
        endcase
      end
    end
  endtask

  // one long set, then more sets, with no idling on either side
  task automatic test_long_set();
    idle_enable = 1'b0;
    for (int i = 0; i < LongSet; i++) send_sample(24'($urandom()), i == LongSet - 1);
    test_random_sets(10);
    idle_enable = 1'b1;
  endtask

  task automatic test_quantile_settings();
    write_quantile(16'hFFFF);
    send_sample(24'h7FFFFF, 1'b0);
    send_sample(24'h800000, 1'b1);
    test_random_sets(10);
    write_quantile(16'h0000);
    test_random_sets(10);
    write_quantile(16'h0001);
    test_random_sets(10);
    write_quantile(16'hA5A5);
    test_random_sets(10);
    write_quantile(QuantileReset);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_sets(25);
    wait_drained();                              // sender holds off until drained
    test_quantile_settings();
    test_long_set();
    wait_drained();
    $display("%0d samples sent, %0d results checked, quantile swept over its range,",
             samples_sent, results_seen);
    $display("including single-sample, zero-variance, extreme and long sets.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
